### rtl/cci_pkg.sv
package cci_pkg;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_CONTACT_DIST = 2'd0;
	localparam logic [1:0] REG_PUCK_MASS    = 2'd1;
	localparam logic [1:0] REG_STRIKER_MASS = 2'd2;

	// Reset values of the registers.
	localparam logic [14:0] CONTACT_DIST_RST = 15'd256;
	localparam logic [15:0] PUCK_MASS_RST    = 16'd256;
	localparam logic [15:0] STRIKER_MASS_RST = 16'd256;

	// Pipeline shape: geometry stages, divider steps, post stages.
	localparam int GEO_STAGES  = 5;
	localparam int DIV_STEPS   = 18;
	localparam int POST_STAGES = 2;
	localparam int NUM_STAGES  = GEO_STAGES + DIV_STEPS + POST_STAGES;

	// Divider widths: projection numerator over squared distance, and mass ratio.
	localparam int Q_NW  = 47;
	localparam int D2_W  = 30;
	localparam int F_NW  = 33;
	localparam int F_DW  = 17;

	typedef struct packed {
		logic signed [15:0] puck_x;
		logic signed [15:0] puck_z;
		logic signed [15:0] puck_vx;
		logic signed [15:0] puck_vz;
		logic signed [15:0] striker_x;
		logic signed [15:0] striker_z;
		logic signed [15:0] striker_vx;
		logic signed [15:0] striker_vz;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] new_vx;
		logic signed [15:0] new_vz;
		logic               contact;
		logic               clipped;
	} out_item_t;

	// Geometry front end result, handed to the dividers.
	typedef struct packed {
		logic [Q_NW-1:0]    mag_x;
		logic [Q_NW-1:0]    mag_z;
		logic               neg_x;
		logic               neg_z;
		logic [D2_W-1:0]    d2;
		logic               hit;
		logic signed [15:0] pvx;
		logic signed [15:0] pvz;
		logic [F_NW-1:0]    fnum;
		logic [F_DW-1:0]    ftot;
	} geo_t;

	// Side information that travels next to the dividers.
	typedef struct packed {
		logic               neg_x;
		logic               neg_z;
		logic               hit;
		logic               tot_zero;
		logic signed [15:0] pvx;
		logic signed [15:0] pvz;
	} side_t;

endpackage

### rtl/cci_geom.sv
module cci_geom import cci_pkg::*; (
	input  logic                  clk,
	input  logic [GEO_STAGES-1:0] en,
	input  in_item_t              item,
	input  logic [14:0]           contact_dist,
	input  logic [15:0]           puck_mass,
	input  logic [15:0]           striker_mass,
	output geo_t                  geo
);

	logic signed [16:0] dx_s1, dz_s1, rvx_s1, rvz_s1;
	logic signed [15:0] pvx_s1, pvz_s1, pvx_s2, pvz_s2, pvx_s3, pvz_s3, pvx_s4, pvz_s4;
	logic [14:0]        cd_s1;
	logic [F_NW-1:0]    fnum_s1, fnum_s2, fnum_s3, fnum_s4;
	logic [F_DW-1:0]    ftot_s1, ftot_s2, ftot_s3, ftot_s4;

	logic signed [33:0] dx2_s2, dz2_s2, px_s2, pz_s2;
	logic [29:0]        cd2_s2;
	logic signed [15:0] dx_s2, dz_s2;

	logic [34:0]        d2w;
	logic signed [34:0] sw;
	logic [D2_W-1:0]    d2_s3, d2_s4;
	logic signed [32:0] s_s3;
	logic signed [15:0] dx_s3, dz_s3;
	logic               hit_s3, hit_s4;

	logic signed [47:0] nx_s4, nz_s4, negx, negz;
	geo_t               geo_s5;

	// Stage 1: offsets, relative velocity, mass ratio operands.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx_s1   <= {item.puck_x[15], item.puck_x} - {item.striker_x[15], item.striker_x};
			dz_s1   <= {item.puck_z[15], item.puck_z} - {item.striker_z[15], item.striker_z};
			rvx_s1  <= {item.puck_vx[15], item.puck_vx} - {item.striker_vx[15], item.striker_vx};
			rvz_s1  <= {item.puck_vz[15], item.puck_vz} - {item.striker_vz[15], item.striker_vz};
			pvx_s1  <= item.puck_vx;
			pvz_s1  <= item.puck_vz;
			cd_s1   <= contact_dist;
			fnum_s1 <= {striker_mass, 17'd0};
			ftot_s1 <= {1'b0, puck_mass} + {1'b0, striker_mass};
		end
	end

	// Stage 2: squares and dot product terms.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			dx2_s2  <= dx_s1 * dx_s1;
			dz2_s2  <= dz_s1 * dz_s1;
			px_s2   <= rvx_s1 * dx_s1;
			pz_s2   <= rvz_s1 * dz_s1;
			cd2_s2  <= cd_s1 * cd_s1;
			dx_s2   <= dx_s1[15:0];
			dz_s2   <= dz_s1[15:0];
			pvx_s2  <= pvx_s1;
			pvz_s2  <= pvz_s1;
			fnum_s2 <= fnum_s1;
			ftot_s2 <= ftot_s1;
		end
	end

	// Stage 3: squared distance, closing speed, contact decision.
	assign d2w = {1'b0, dx2_s2} + {1'b0, dz2_s2};
	assign sw  = $signed({px_s2[33], px_s2}) + $signed({pz_s2[33], pz_s2});

	always_ff @(posedge clk) begin
		if (en[2]) begin
			// Offsets fit 16 bits and the dot product 33 bits whenever contact holds.
			hit_s3  <= (d2w != '0) && (d2w <= {5'd0, cd2_s2}) && sw[34];
			d2_s3   <= d2w[D2_W-1:0];
			s_s3    <= sw[32:0];
			dx_s3   <= dx_s2;
			dz_s3   <= dz_s2;
			pvx_s3  <= pvx_s2;
			pvz_s3  <= pvz_s2;
			fnum_s3 <= fnum_s2;
			ftot_s3 <= ftot_s2;
		end
	end

	// Stage 4: projection numerators.
	always_ff @(posedge clk) begin
		if (en[3]) begin
			nx_s4   <= s_s3 * dx_s3;
			nz_s4   <= s_s3 * dz_s3;
			hit_s4  <= hit_s3;
			d2_s4   <= d2_s3;
			pvx_s4  <= pvx_s3;
			pvz_s4  <= pvz_s3;
			fnum_s4 <= fnum_s3;
			ftot_s4 <= ftot_s3;
		end
	end

	// Stage 5: sign and magnitude for the unsigned dividers.
	assign negx = -nx_s4;
	assign negz = -nz_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			geo_s5.neg_x <= nx_s4[47];
			geo_s5.neg_z <= nz_s4[47];
			geo_s5.mag_x <= nx_s4[47] ? negx[Q_NW-1:0] : nx_s4[Q_NW-1:0];
			geo_s5.mag_z <= nz_s4[47] ? negz[Q_NW-1:0] : nz_s4[Q_NW-1:0];
			geo_s5.d2    <= d2_s4;
			geo_s5.hit   <= hit_s4;
			geo_s5.pvx   <= pvx_s4;
			geo_s5.pvz   <= pvz_s4;
			geo_s5.fnum  <= fnum_s4;
			geo_s5.ftot  <= ftot_s4;
		end
	end

	assign geo = geo_s5;

endmodule

### rtl/cci_udiv.sv
module cci_udiv #(
	parameter int NW = 47,
	parameter int DW = 30,
	parameter int QW = 18
) (
	input  logic          clk,
	input  logic [QW-1:0] en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quot
);

	localparam int LW = (NW > DW + QW) ? NW : DW + QW;

	logic [NW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quot_s [QW];

	// One restoring step per stage, most significant quotient bit first.
	for (genvar j = 0; j < QW; j++) begin : g_step
		logic [NW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] quot_in;
		logic [LW-1:0] shifted, diff;
		logic          ge;

		if (j == 0) begin : g_first
			assign rem_in  = num;
			assign den_in  = den;
			assign quot_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[j-1];
			assign den_in  = den_s[j-1];
			assign quot_in = quot_s[j-1];
		end

		assign shifted = LW'(den_in) << (QW - 1 - j);
		assign ge      = LW'(rem_in) >= shifted;
		assign diff    = LW'(rem_in) - shifted;

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j]  <= ge ? diff[NW-1:0] : rem_in;
				den_s[j]  <= den_in;
				quot_s[j] <= quot_in | (QW'(ge) << (QW - 1 - j));
			end
		end
	end

	assign quot = quot_s[QW-1];

endmodule

### rtl/cci_post.sv
module cci_post import cci_pkg::*; (
	input  logic                   clk,
	input  logic [POST_STAGES-1:0] en,
	input  logic [DIV_STEPS-1:0]   qx,
	input  logic [DIV_STEPS-1:0]   qz,
	input  logic [DIV_STEPS-1:0]   f,
	input  side_t                  side,
	output out_item_t              result
);

	logic [DIV_STEPS-1:0]   fe;
	logic [2*DIV_STEPS-1:0] prodx, prodz;
	logic [19:0]            dlx_s1, dlz_s1;
	side_t                  side_s1;
	logic signed [21:0]     nvx, nvz;
	logic                   hix, lox, hiz, loz;
	out_item_t              res_s2;

	// Stage 1: scale the projections by the mass ratio in Q1.17.
	assign fe    = side.tot_zero ? '0 : f;
	assign prodx = qx * fe;
	assign prodz = qz * fe;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dlx_s1  <= prodx[35:16];
			dlz_s1  <= prodz[35:16];
			side_s1 <= side;
		end
	end

	// Stage 2: subtract the signed delta and saturate.
	assign nvx = side_s1.neg_x ? ($signed({{6{side_s1.pvx[15]}}, side_s1.pvx}) + $signed({2'b00, dlx_s1}))
	                           : ($signed({{6{side_s1.pvx[15]}}, side_s1.pvx}) - $signed({2'b00, dlx_s1}));
	assign nvz = side_s1.neg_z ? ($signed({{6{side_s1.pvz[15]}}, side_s1.pvz}) + $signed({2'b00, dlz_s1}))
	                           : ($signed({{6{side_s1.pvz[15]}}, side_s1.pvz}) - $signed({2'b00, dlz_s1}));
	assign hix = nvx > 22'sd32767;
	assign lox = nvx < -22'sd32768;
	assign hiz = nvz > 22'sd32767;
	assign loz = nvz < -22'sd32768;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			if (side_s1.hit) begin
				res_s2.new_vx  <= hix ? 16'sh7FFF : (lox ? 16'sh8000 : nvx[15:0]);
				res_s2.new_vz  <= hiz ? 16'sh7FFF : (loz ? 16'sh8000 : nvz[15:0]);
				res_s2.contact <= 1'b1;
				res_s2.clipped <= hix | lox | hiz | loz;
			end else begin
				res_s2.new_vx  <= side_s1.pvx;
				res_s2.new_vz  <= side_s1.pvz;
				res_s2.contact <= 1'b0;
				res_s2.clipped <= 1'b0;
			end
		end
	end

	assign result = res_s2;

endmodule

### rtl/circle_collision_impulse.sv
// Elastic impulse of a striker on a puck in the horizontal plane.
// Input channel: in_valid / in_stall / in_data carry one request of puck and
// striker positions and velocities. Output channel: out_valid / out_stall /
// out_data carry the new puck velocity with contact and clipped flags.
// Exactly one result leaves for each accepted request, in order.
// Configuration: cfg_we writes cfg_data into the register cfg_index selects
// (contact distance, puck mass, striker mass); write only while idle.
// The pipeline has five geometry stages, an 18-step pipelined restoring
// divider (one quotient bit per stage) and two scale/saturate stages.
// Throughput: one request per cycle unless stalled; divider stages set depth.
// Reset clears all stage valid bits and loads the register reset values;
// the block accepts a request in the first cycle after reset.
// When the receiver stalls, each stage holds while it is full and the one
// after it is held; empty stages still fill, so requests keep entering
// until every stage is occupied, then in_stall rises.
module circle_collision_impulse import cci_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [14:0]           contact_dist_q;
	logic [15:0]           puck_mass_q, striker_mass_q;
	logic [NUM_STAGES-1:0] v_q;
	logic [NUM_STAGES:0]   rdy;
	geo_t                  geo;
	side_t                 side_s [DIV_STEPS];
	side_t                 side_in;
	logic [DIV_STEPS-1:0]  qx, qz, fq;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contact_dist_q <= CONTACT_DIST_RST;
			puck_mass_q    <= PUCK_MASS_RST;
			striker_mass_q <= STRIKER_MASS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CONTACT_DIST: contact_dist_q <= cfg_data[14:0];
				REG_PUCK_MASS:    puck_mass_q    <= cfg_data;
				REG_STRIKER_MASS: striker_mass_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or the stage after it moves on.
	always_comb begin
		rdy[NUM_STAGES] = !out_stall;
		for (int k = NUM_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !v_q[k] | rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = v_q[NUM_STAGES-1];

	// Geometry front end.
	cci_geom u_geom (
		.clk          (clk),
		.en           (rdy[GEO_STAGES-1:0]),
		.item         (in_data),
		.contact_dist (contact_dist_q),
		.puck_mass    (puck_mass_q),
		.striker_mass (striker_mass_q),
		.geo          (geo)
	);

	// Dividers for both projections and the mass ratio.
	cci_udiv #(.NW(Q_NW), .DW(D2_W), .QW(DIV_STEPS)) u_div_x (
		.clk  (clk),
		.en   (rdy[GEO_STAGES +: DIV_STEPS]),
		.num  (geo.mag_x),
		.den  (geo.d2),
		.quot (qx)
	);

	cci_udiv #(.NW(Q_NW), .DW(D2_W), .QW(DIV_STEPS)) u_div_z (
		.clk  (clk),
		.en   (rdy[GEO_STAGES +: DIV_STEPS]),
		.num  (geo.mag_z),
		.den  (geo.d2),
		.quot (qz)
	);

	cci_udiv #(.NW(F_NW), .DW(F_DW), .QW(DIV_STEPS)) u_div_f (
		.clk  (clk),
		.en   (rdy[GEO_STAGES +: DIV_STEPS]),
		.num  (geo.fnum),
		.den  (geo.ftot),
		.quot (fq)
	);

	// Side information alongside the divider stages.
	assign side_in.neg_x    = geo.neg_x;
	assign side_in.neg_z    = geo.neg_z;
	assign side_in.hit      = geo.hit;
	assign side_in.tot_zero = (geo.ftot == '0);
	assign side_in.pvx      = geo.pvx;
	assign side_in.pvz      = geo.pvz;

	always_ff @(posedge clk) begin
		if (rdy[GEO_STAGES]) begin
			side_s[0] <= side_in;
		end
		for (int j = 1; j < DIV_STEPS; j++) begin
			if (rdy[GEO_STAGES + j]) begin
				side_s[j] <= side_s[j-1];
			end
		end
	end

	// Scaling, saturation and output register.
	cci_post u_post (
		.clk    (clk),
		.en     (rdy[NUM_STAGES-1 -: POST_STAGES]),
		.qx     (qx),
		.qz     (qz),
		.f      (fq),
		.side   (side_s[DIV_STEPS-1]),
		.result (out_data)
	);

	// A result without contact leaves the velocity untouched, so never clips.
	a_no_clip_without_contact: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.contact |-> !out_data.clipped)
		else $error("clipped set on a result without contact");

	// The input side only stalls while the receiver holds the output.
	a_stall_only_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output flows");

	// An accepted request occupies the first stage next cycle.
	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_q[0])
		else $error("accepted request lost at entry");

endmodule
